### hdl/mrt_pkg.sv
package mrt_pkg;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_FAULT = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ADDR_NZ   = 4'd1,
    ST_ZERO_LEN  = 4'd2,
    ST_BAD_FILE  = 4'd3,
    ST_PERM      = 4'd4,
    ST_NO_SLOT   = 4'd5,
    ST_NO_SPACE  = 4'd6,
    ST_NOT_MAP   = 4'd7,
    ST_MIDDLE    = 4'd8,
    ST_PRESENT   = 4'd9
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_GAP_INIT,
    S_GAP_SCAN,
    S_GAP_NEXT,
    S_MAP_WR,
    S_FIND,
    S_UNMAP,
    S_FAULT,
    S_OUT
  } state_e;

  localparam int unsigned CFG_HEAP_TOP   = 0;
  localparam int unsigned CFG_GUARD_BASE = 1;
  localparam int unsigned SLOTS          = 16;
  localparam int unsigned VA_BITS        = 38;
  localparam int unsigned LEN_W          = 39;
  localparam int unsigned OFF_W          = 32;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned IN_BITS        = 2 + VA_BITS + LEN_W + 3 + 1 + 8 + OFF_W + 4;
  localparam int unsigned IN_W           = (IN_BITS + 7) / 8 * 8;
  localparam int unsigned OUT_BITS       = 4 + VA_BITS + OFF_W + 4 + 4 + 8 + 1 + 1;
  localparam int unsigned OUT_W          = (OUT_BITS + 7) / 8 * 8;

endpackage

### hdl/mapped_region_table.sv
// Region table with map, unmap and fault lookup. One request at a time:
// tready is high only while idle with no result waiting, and the result sits
// in an output register until taken. A single compare/add datapath walks the
// slots one per cycle. Unmap and fault: the slot search, then the update state
// (S_UNMAP or S_FAULT), then S_OUT, which raises tvalid. A map finds a free
// slot, sets up the gap search, then tries up to SLOTS+2 gap candidates, each
// checked against the slots, and then writes the slot and reports.
// heap_top is cfg index 0, guard_base index 1, both 39 bit.
module mapped_region_table
  import mrt_pkg::*;
#(
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, addr, length, prot, shared, file_id, map_offset, file_open,
  // file_readable, file_writable, page_present
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, result_addr, page_offset, perm, slot, region_file,
  // released, region_shared
  output logic [OUT_W-1:0]     m_axis_tdata
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS + 3);
  localparam int unsigned AW = VA_BITS + 2;
  localparam int unsigned OW = $bits(m_axis_tdata);

  localparam logic [AW-1:0] PG_MASK = AW'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [AW-1:0] VA_LAST = AW'((64'd1 << VA_BITS) - (64'd1 << PAGE_BITS));

  // region store
  logic                 used_q [SLOTS];
  logic [VA_BITS-1:0]   base_q [SLOTS];
  logic [LEN_W-1:0]     len_q  [SLOTS];
  logic [OFF_W-1:0]     off_q  [SLOTS];
  logic [2:0]           prot_q [SLOTS];
  logic                 shr_q  [SLOTS];
  logic [7:0]           fid_q  [SLOTS];

  logic [LEN_W-1:0] heap_q, guard_q;
  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] iter_q, iter_d;
  logic [SW-1:0] hit_q, hit_d;
  logic [AW-1:0] cand_q, cand_d, sz_q, sz_d;

  // request fields
  logic [1:0] op_q;
  logic [VA_BITS-1:0] addr_q;
  logic [LEN_W-1:0] rlen_q;
  logic [2:0] rprot_q;
  logic rshr_q;
  logic [7:0] rfid_q;
  logic [OFF_W-1:0] roff_q;
  logic ropen_q, rrd_q, rwr_q, rpres_q;

  logic [OW-1:0] out_q, out_d;
  logic ovalid_q;
  logic wr_map, wr_unmap;

  logic [SW-1:0] i_s;
  logic [AW-1:0] rb, re, addr_x;
  logic in_reg, ovl;

  assign i_s    = idx_q[SW-1:0];
  assign rb     = AW'(base_q[i_s]);
  assign re     = rb + AW'(len_q[i_s]);
  assign addr_x = AW'(addr_q);
  assign in_reg = used_q[i_s] && addr_x >= rb && addr_x < re;
  assign ovl    = used_q[i_s] && !((cand_q + sz_q <= rb) || (cand_q >= re));

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  function automatic logic [OW-1:0] pack_out(
    status_e st, logic [VA_BITS-1:0] ra, logic [OFF_W-1:0] po, logic [3:0] pm,
    logic [SW-1:0] sl, logic [7:0] rf, logic rel, logic rs);
    logic [OW-1:0] r;
    r = '0;
    r[3:0] = st;
    r[4 +: VA_BITS] = ra;
    r[4+VA_BITS +: OFF_W] = po;
    r[4+VA_BITS+OFF_W +: 4] = pm;
    r[8+VA_BITS+OFF_W +: 4] = 4'(sl);
    r[12+VA_BITS+OFF_W +: 8] = rf;
    r[20+VA_BITS+OFF_W] = rel;
    r[21+VA_BITS+OFF_W] = rs;
    return r;
  endfunction

  logic [AW-1:0] lim, g_minus, c0;
  assign lim     = AW'(heap_q) + sz_q;
  assign g_minus = (AW'(guard_q) - sz_q) & ~PG_MASK;
  assign c0      = (g_minus > VA_LAST) ? VA_LAST : g_minus;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    iter_d   = iter_q;
    hit_d    = hit_q;
    cand_d   = cand_q;
    sz_d     = sz_q;
    out_d    = out_q;
    wr_map   = 1'b0;
    wr_unmap = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d  = '0;
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (op_e'(s_axis_tdata[1:0]))
            OP_MAP:   state_d = S_FREE;
            OP_UNMAP: state_d = S_FIND;
            OP_FAULT: state_d = S_FIND;
            default: begin
              out_d   = pack_out(ST_NOT_MAP, '0, '0, '0, '0, '0, 1'b0, 1'b0);
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_FREE: begin
        sz_d = (AW'(rlen_q) + PG_MASK) & ~PG_MASK;
        if (addr_q != '0) begin
          out_d = pack_out(ST_ADDR_NZ, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if (rlen_q == '0) begin
          out_d = pack_out(ST_ZERO_LEN, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if (!ropen_q) begin
          out_d = pack_out(ST_BAD_FILE, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if ((rshr_q && rprot_q[1] && !rwr_q) || !rrd_q) begin
          out_d = pack_out(ST_PERM, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if (idx_q == CW'(SLOTS)) begin
          out_d = pack_out(ST_NO_SLOT, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if (!used_q[i_s]) begin
          hit_d   = i_s;
          state_d = S_GAP_INIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_GAP_INIT: begin
        // free slot stays in hit_q until the write
        iter_d = '0;
        idx_d  = '0;
        if (AW'(guard_q) < sz_q) begin
          out_d = pack_out(ST_NO_SPACE, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else begin
          cand_d  = c0;
          state_d = S_GAP_SCAN;
        end
      end
      S_GAP_SCAN: begin
        if (idx_q == '0 && cand_q < lim) begin
          out_d = pack_out(ST_NO_SPACE, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if (idx_q == CW'(SLOTS)) begin
          state_d = S_MAP_WR;
        end else if (ovl) begin
          state_d = S_GAP_NEXT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_GAP_NEXT: begin
        // hit slot index still in idx_q
        idx_d = '0;
        if (rb < sz_q || iter_q == IW'(SLOTS + 1)) begin
          out_d = pack_out(ST_NO_SPACE, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else begin
          cand_d  = (rb - sz_q) & ~PG_MASK;
          iter_d  = iter_q + 1'b1;
          state_d = S_GAP_SCAN;
        end
      end
      S_MAP_WR: begin
        wr_map  = 1'b1;
        out_d   = pack_out(ST_OK, cand_q[VA_BITS-1:0], '0, '0, hit_q, rfid_q, 1'b0, rshr_q);
        state_d = S_OUT;
      end
      S_FIND: begin
        if (idx_q == CW'(SLOTS)) begin
          out_d = pack_out(ST_NOT_MAP, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          state_d = S_OUT;
        end else if (in_reg) begin
          hit_d   = i_s;
          state_d = (op_q == OP_UNMAP) ? S_UNMAP : S_FAULT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_UNMAP: begin
        if (addr_x != AW'(base_q[hit_q]) &&
            addr_x + AW'(rlen_q) != AW'(base_q[hit_q]) + AW'(len_q[hit_q])) begin
          out_d = pack_out(ST_MIDDLE, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        end else begin
          wr_unmap = 1'b1;
          out_d = pack_out(ST_OK, '0, '0, '0, hit_q, fid_q[hit_q],
                           (addr_q == base_q[hit_q]) && (rlen_q >= len_q[hit_q]),
                           shr_q[hit_q]);
        end
        state_d = S_OUT;
      end
      S_FAULT: begin
        if (rpres_q) begin
          out_d = pack_out(ST_PRESENT, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        end else begin
          out_d = pack_out(ST_OK, addr_q & ~PG_MASK[VA_BITS-1:0],
                           off_q[hit_q] + OFF_W'((addr_q & ~PG_MASK[VA_BITS-1:0])
                                                 - base_q[hit_q]),
                           {1'b1, prot_q[hit_q]}, hit_q, fid_q[hit_q], 1'b0,
                           shr_q[hit_q]);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      iter_q   <= '0;
      ovalid_q <= 1'b0;
      heap_q   <= '0;
      guard_q  <= LEN_W'(39'd274877898752);
      for (int k = 0; k < SLOTS; k++) used_q[k] <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      iter_q  <= iter_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_W'(CFG_HEAP_TOP)) heap_q <= cfg_data_i;
        else guard_q <= cfg_data_i;
      end
      if (state_q == S_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (wr_map) used_q[hit_q] <= 1'b1;
      if (wr_unmap && addr_q == base_q[hit_q] && rlen_q >= len_q[hit_q])
        used_q[hit_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    cand_q <= cand_d;
    sz_q   <= sz_d;
    out_q  <= out_d;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tdata[1:0];
      addr_q  <= s_axis_tdata[2 +: VA_BITS];
      rlen_q  <= s_axis_tdata[2+VA_BITS +: LEN_W];
      rprot_q <= s_axis_tdata[2+VA_BITS+LEN_W +: 3];
      rshr_q  <= s_axis_tdata[5+VA_BITS+LEN_W];
      rfid_q  <= s_axis_tdata[6+VA_BITS+LEN_W +: 8];
      roff_q  <= s_axis_tdata[14+VA_BITS+LEN_W +: OFF_W];
      ropen_q <= s_axis_tdata[14+VA_BITS+LEN_W+OFF_W];
      rrd_q   <= s_axis_tdata[15+VA_BITS+LEN_W+OFF_W];
      rwr_q   <= s_axis_tdata[16+VA_BITS+LEN_W+OFF_W];
      rpres_q <= s_axis_tdata[17+VA_BITS+LEN_W+OFF_W];
    end
    if (wr_map) begin
      base_q[hit_q] <= cand_q[VA_BITS-1:0];
      len_q[hit_q]  <= sz_q[LEN_W-1:0];
      off_q[hit_q]  <= roff_q;
      prot_q[hit_q] <= rprot_q;
      shr_q[hit_q]  <= rshr_q;
      fid_q[hit_q]  <= rfid_q;
    end
    if (wr_unmap && !(addr_q == base_q[hit_q] && rlen_q >= len_q[hit_q])) begin
      len_q[hit_q] <= len_q[hit_q] - rlen_q;
      if (addr_q == base_q[hit_q]) begin
        base_q[hit_q] <= base_q[hit_q] + rlen_q[VA_BITS-1:0];
        off_q[hit_q]  <= off_q[hit_q] + rlen_q[OFF_W-1:0];
      end
    end
  end
endmodule

### hdl/mrt_checker.sv
module mrt_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [3:0] status_i
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status_i <= 4'd9) else $error("bad status");
endmodule

bind mapped_region_table mrt_sva u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .status_i(m_axis_tdata[3:0])
);
